// ===== design/dhti_pkg.sv =====
// Shared types, widths and codes for the double-hashing insert table.
package dhti_pkg;

  localparam int KEY_W          = 32;
  localparam int SLOT_W         = 7;
  localparam int SIZE_W         = 8;
  localparam int CODE_W         = 2;
  localparam int TABLE_DEPTH_DEF = 128;
  localparam int DIV_STEPS      = KEY_W;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic [SIZE_W-1:0] TSIZE_RST = SIZE_W'(127);
  localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(2);

  localparam logic [CODE_W-1:0] RES_INSERTED = 2'd0;
  localparam logic [CODE_W-1:0] RES_FULL     = 2'd1;
  localparam logic [CODE_W-1:0] RES_READ     = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{occ: 1'b0, key: '1};

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] h1;
    logic [SIZE_W-1:0] h2;
  } hash_res_t;

endpackage

// ===== design/dhti_ram.sv =====
// Single-port synchronous RAM with registered read data.
module dhti_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/dhti_hash.sv =====
// Bit-serial unit that forms both floored hash remainders of a signed key.
module dhti_hash
  import dhti_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [SIZE_W-1:0] size_i,
  output hash_res_t         res_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0]     mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic [SIZE_W-1:0]    d1_q, d1_d, d2_q, d2_d;
  logic [SIZE_W-1:0]    r1_q, r1_d, r2_q, r2_d;
  logic [SIZE_W:0]      t1, t2;
  logic [SIZE_W-1:0]    f1, f2;

  always_comb begin
    t1 = {r1_q, mag_q[KEY_W-1]};
    t2 = {r2_q, mag_q[KEY_W-1]};
    if (t1 >= {1'b0, d1_q}) begin
      t1 = t1 - {1'b0, d1_q};
    end
    if (t2 >= {1'b0, d2_q}) begin
      t2 = t2 - {1'b0, d2_q};
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    d1_d   = d1_q;
    d2_d   = d2_q;
    r1_d   = r1_q;
    r2_d   = r2_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = key_i[KEY_W-1];
      mag_d  = key_i[KEY_W-1] ? (~key_i + KEY_W'(1)) : key_i;
      d1_d   = size_i;
      d2_d   = size_i - SIZE_W'(1);
      r1_d   = '0;
      r2_d   = '0;
    end else if (busy_q) begin
      mag_d = {mag_q[KEY_W-2:0], 1'b0};
      r1_d  = t1[SIZE_W-1:0];
      r2_d  = t2[SIZE_W-1:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    d1_q  <= d1_d;
    d2_q  <= d2_d;
    r1_q  <= r1_d;
    r2_q  <= r2_d;
  end

  assign f1 = (neg_q && (r1_q != '0)) ? (d1_q - r1_q) : r1_q;
  assign f2 = (neg_q && (r2_q != '0)) ? (d2_q - r2_q) : r2_q;

  assign res_o = '{done: done_q, h1: f1, h2: f2 + SIZE_W'(1)};

endmodule

// ===== design/double_hash_table_insert.sv =====
// Top level of the double-hashing insert table with APB size register.
// Read: accept, a table read if the index is in range, then output. Insert: accept, hashing,
// then one table read per probe (up to m probes), a write if a free slot is found, then output.
// One request is in work at a time; the next one is taken while a result waits at the output.
// After reset a clearing pass writes every slot empty and no request is taken
// meanwhile; table_size resets to 127.
module double_hash_table_insert
  import dhti_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int AW         = $clog2(TABLE_DEPTH)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // key[31:0], slot_index[38:32], zero pad
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // slot[6:0], slot_key[38:7], slot_occupied[39]
  output logic [1:0]  m_axis_tuser,   // result_code
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [SIZE_W-1:0] tsize_q;
  logic [SIZE_W-1:0] m_q, m_d, m_eff;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [SIZE_W-1:0] pos_q, pos_d, step_q, step_d, ppos_q, ppos_d, cnt_q, cnt_d;
  logic              pv_q, pv_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [CODE_W-1:0] rcode_q, rcode_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic [KEY_W-1:0]  rkey_q, rkey_d;
  logic              rocc_q, rocc_d;
  logic              ovalid_q, ovalid_d;
  logic [CODE_W-1:0] ocode_q, ocode_d;
  logic [SLOT_W-1:0] oslot_q, oslot_d;
  logic [KEY_W-1:0]  okey_q, okey_d;
  logic              oocc_q, oocc_d;

  logic              in_acc, out_free, issue, idx_ok, cfg_wr;
  logic [SIZE_W:0]   pos_sum;
  logic [KEY_W-1:0]  in_key;
  logic [SLOT_W-1:0] in_idx;
  logic              hash_start;
  hash_res_t         hash_res;
  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  entry_t            ram_wdata, ram_rdata;

  assign in_key   = s_axis_tdata[KEY_W-1:0];
  assign in_idx   = s_axis_tdata[KEY_W+SLOT_W-1:KEY_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign idx_ok   = {25'd0, in_idx} < 32'(TABLE_DEPTH);
  assign issue    = (cnt_q != m_q);
  assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};

  assign m_eff = (tsize_q < SIZE_MIN) ? SIZE_MIN :
                 ((32'(tsize_q) > TABLE_DEPTH) ? SIZE_W'(TABLE_DEPTH) : tsize_q);

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, tsize_q} : 32'd0;

  assign s_axis_tready = (state_q == S_IDLE);

  dhti_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (in_key),
    .size_i  (m_eff),
    .res_o   (hash_res)
  );

  dhti_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    m_d        = m_q;
    key_d      = key_q;
    pos_d      = pos_q;
    step_d     = step_q;
    ppos_d     = ppos_q;
    cnt_d      = cnt_q;
    pv_d       = pv_q;
    clr_d      = clr_q;
    rcode_d    = rcode_q;
    rslot_d    = rslot_q;
    rkey_d     = rkey_q;
    rocc_d     = rocc_q;
    ovalid_d   = ovalid_q && !m_axis_tready;
    ocode_d    = ocode_q;
    oslot_d    = oslot_q;
    okey_d     = okey_q;
    oocc_d     = oocc_q;
    hash_start = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = AW'(pos_q);
    ram_wdata  = ENTRY_EMPTY;

    case (state_q)
      S_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == REQ_READ) begin
            rcode_d = RES_READ;
            rslot_d = in_idx;
            if (idx_ok) begin
              ram_en   = 1'b1;
              ram_addr = AW'(in_idx);
              state_d  = S_RDWAIT;
            end else begin
              rkey_d  = '1;
              rocc_d  = 1'b0;
              state_d = S_DONE;
            end
          end else begin
            hash_start = 1'b1;
            key_d      = in_key;
            m_d        = m_eff;
            state_d    = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_res.done) begin
          pos_d   = hash_res.h1;
          step_d  = hash_res.h2;
          cnt_d   = '0;
          pv_d    = 1'b0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (pv_q && !ram_rdata.occ) begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_addr  = AW'(ppos_q);
          ram_wdata = '{occ: 1'b1, key: key_q};
          rcode_d   = RES_INSERTED;
          rslot_d   = SLOT_W'(ppos_q);
          rkey_d    = key_q;
          rocc_d    = 1'b1;
          state_d   = S_DONE;
        end else if (issue) begin
          ram_en = 1'b1;
          ppos_d = pos_q;
          pv_d   = 1'b1;
          cnt_d  = cnt_q + SIZE_W'(1);
          pos_d  = (pos_sum >= {1'b0, m_q}) ? SIZE_W'(pos_sum - {1'b0, m_q})
                                            : pos_sum[SIZE_W-1:0];
        end else begin
          pv_d    = 1'b0;
          rcode_d = RES_FULL;
          rslot_d = '0;
          rkey_d  = '0;
          rocc_d  = 1'b0;
          state_d = S_DONE;
        end
      end
      S_RDWAIT: begin
        rkey_d  = ram_rdata.key;
        rocc_d  = ram_rdata.occ;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ocode_d  = rcode_q;
          oslot_d  = rslot_q;
          okey_d   = rkey_q;
          oocc_d   = rocc_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      tsize_q  <= TSIZE_RST;
      ovalid_q <= 1'b0;
      pv_q     <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
      pv_q     <= pv_d;
      cnt_q    <= cnt_d;
      if (cfg_wr && (paddr[2] == 1'b0)) begin
        tsize_q <= pwdata[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    key_q   <= key_d;
    pos_q   <= pos_d;
    step_q  <= step_d;
    ppos_q  <= ppos_d;
    rcode_q <= rcode_d;
    rslot_q <= rslot_d;
    rkey_q  <= rkey_d;
    rocc_q  <= rocc_d;
    ocode_q <= ocode_d;
    oslot_q <= oslot_d;
    okey_q  <= okey_d;
    oocc_q  <= oocc_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ocode_q;
  assign m_axis_tdata  = {oocc_q, okey_q, oslot_q};

endmodule

// ===== sim/double_hash_table_insert_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for double_hash_table_insert: directed and random requests vs a predictor.
module double_hash_table_insert_tb;
  import dhti_pkg::*;

  localparam int         CLK_HALF        = 5;
  localparam int         CYCLE_LIMIT     = 1_000_000;
  localparam int         PHASE_ITEMS     = 103;
  localparam int         DRAIN_CYCLES    = 200;
  localparam int         SQUEEZE_CYCLES  = 300;
  localparam int         IDLE_PCT        = 37;
  localparam int         MAX_REPORTS     = 10;
  localparam logic [2:0] TABLE_SIZE_ADDR = 3'd0;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic              occ;
  } outcome_t;

  typedef struct {
    row_kind_e         kind;
    logic              req;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] idx;
    logic [SIZE_W-1:0] size;
    bit                typed;
    outcome_t          want;
  } stim_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // key[31:0], slot_index[38:32], zero pad
  logic        s_axis_tuser  = 1'b0; // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // slot[6:0], slot_key[38:7], slot_occupied[39]
  logic [1:0]  m_axis_tuser;         // result_code
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [KEY_W-1:0]  key_mirror [TABLE_DEPTH_DEF];
  logic              occ_mirror [TABLE_DEPTH_DEF];
  logic [SIZE_W-1:0] size_mirror;
  outcome_t          pending_results [$];

  bit steady      = 1'b0;
  bit squeeze_req = 1'b0;
  int cycle_count = 0;
  int mismatches  = 0;
  int n_sent      = 0;
  int n_inserted  = 0;
  int n_full      = 0;
  int n_read      = 0;
  int n_sizes     = 0;

  double_hash_table_insert DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic outcome_t predict_request(logic req, logic [KEY_W-1:0] key,
                                               logic [SLOT_W-1:0] idx);
    outcome_t res;
    longint   m;
    longint   k;
    longint   pos;
    longint   stride;
    res = '0;
    if (req == REQ_READ) begin
      res.code = RES_READ;
      res.slot = idx;
      res.key  = key_mirror[idx];
      res.occ  = occ_mirror[idx];
      return res;
    end
    m = longint'(size_mirror);
    if (m < 2) m = 2;
    if (m > TABLE_DEPTH_DEF) m = TABLE_DEPTH_DEF;
    k = longint'($signed(key));
    pos = k % m;
    if (pos < 0) pos += m;
    stride = k % (m - 1);
    if (stride < 0) stride += m - 1;
    stride += 1;
    for (longint i = 0; i < m; i++) begin
      if (!occ_mirror[pos]) begin
        key_mirror[pos] = key;
        occ_mirror[pos] = 1'b1;
        res.code = RES_INSERTED;
        res.slot = pos[SLOT_W-1:0];
        res.key  = key;
        res.occ  = 1'b1;
        return res;
      end
      pos += stride;
      if (pos >= m) pos -= m;
    end
    res.code = RES_FULL;
    return res;
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int m);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return KEY_W'(int'($urandom_range(0, 600)) - 300);
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h7FFF_FFFF;
          3: return 32'h8000_0000;
          4: return 32'h8000_0001;
          default: return 32'h7FFF_FFFE;
        endcase
      end
      default: return KEY_W'((int'($urandom_range(0, 2000)) - 1000) * m
                             + int'($urandom_range(0, 3)));
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result(outcome_t want, logic [1:0] code, logic [39:0] data);
    outcome_t got;
    got.code = code;
    got.slot = data[6:0];
    got.key  = data[38:7];
    got.occ  = data[39];
    if (got.code != want.code || got.slot != want.slot ||
        got.key != want.key || got.occ != want.occ) begin
      note_mismatch($sformatf("code %0d/%0d slot %0d/%0d key %h/%h occ %0d/%0d (want/got)",
                              want.code, got.code, want.slot, got.slot,
                              want.key, got.key, want.occ, got.occ));
    end
    case (want.code)
      RES_INSERTED: n_inserted++;
      RES_FULL:     n_full++;
      default:      n_read++;
    endcase
  endtask

  task automatic send_request(logic req, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] idx,
                              bit typed, outcome_t typed_want);
    outcome_t predicted;
    @(negedge clk_i);
    while (take_break()) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req;
    s_axis_tdata  = {1'b0, idx, key};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_request(req, key, idx);
    pending_results.push_back(typed ? typed_want : predicted);
    n_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_table_size(logic [SIZE_W-1:0] value);
    logic [31:0] readback;
    wait_idle();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = TABLE_SIZE_ADDR;
    pwdata  = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    size_mirror = value;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback != 32'(value)) begin
      note_mismatch($sformatf("table_size read back %h, wrote %h", readback, value));
    end
    n_sizes++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing outstanding: code %0d data %h",
                                m_axis_tuser, m_axis_tdata));
      end else begin
        check_result(pending_results.pop_front(), m_axis_tuser, m_axis_tdata);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req) begin
        hold_left   = SQUEEZE_CYCLES;
        squeeze_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = !take_break();
      end
    end
  end

  initial begin : stimulus
    stim_row_t plan [$];
    int        sz_list [10];
    int        m;
    int        sz;

    foreach (key_mirror[i]) begin
      key_mirror[i] = '1;
      occ_mirror[i] = 1'b0;
    end
    size_mirror = TSIZE_RST;

    plan.push_back('{ROW_REQ, REQ_READ, 32'h0000_0000, 7'd0, 8'd0, 1'b1,
                     '{RES_READ, 7'd0, 32'hFFFF_FFFF, 1'b0}});
    plan.push_back('{ROW_REQ, REQ_READ, 32'hFFFF_FFFF, 7'd127, 8'd0, 1'b1,
                     '{RES_READ, 7'd127, 32'hFFFF_FFFF, 1'b0}});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'h0000_0000, 7'd0, 8'd0, 1'b1,
                     '{RES_INSERTED, 7'd0, 32'h0000_0000, 1'b1}});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'd127, 7'd0, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'hFFFF_FFFF, 7'd0, 8'd0, 1'b1,
                     '{RES_INSERTED, 7'd126, 32'hFFFF_FFFF, 1'b1}});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'h7FFF_FFFF, 7'd0, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'h8000_0000, 7'd0, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_READ, 32'h0000_0000, 7'd0, 8'd0, 1'b1,
                     '{RES_READ, 7'd0, 32'h0000_0000, 1'b1}});
    plan.push_back('{ROW_REQ, REQ_READ, 32'h0000_0000, 7'd126, 8'd0, 1'b1,
                     '{RES_READ, 7'd126, 32'hFFFF_FFFF, 1'b1}});
    plan.push_back('{ROW_REQ, REQ_READ, 32'h0000_0000, 7'd2, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_CFG, REQ_READ, 32'h0000_0000, 7'd0, 8'd2, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'd5, 7'd0, 8'd0, 1'b1,
                     '{RES_INSERTED, 7'd1, 32'd5, 1'b1}});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'd6, 7'd0, 8'd0, 1'b1,
                     '{RES_FULL, 7'd0, 32'd0, 1'b0}});
    plan.push_back('{ROW_CFG, REQ_READ, 32'h0000_0000, 7'd0, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'd9, 7'd0, 8'd0, 1'b1,
                     '{RES_FULL, 7'd0, 32'd0, 1'b0}});
    plan.push_back('{ROW_CFG, REQ_READ, 32'h0000_0000, 7'd0, 8'd1, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'hFFFF_FFF9, 7'd0, 8'd0, 1'b1,
                     '{RES_FULL, 7'd0, 32'd0, 1'b0}});
    plan.push_back('{ROW_CFG, REQ_READ, 32'h0000_0000, 7'd0, 8'd128, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'd128, 7'd0, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'hFFFF_FF80, 7'd0, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_CFG, REQ_READ, 32'h0000_0000, 7'd0, 8'd255, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'd255, 7'd0, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_READ, 32'h0000_0000, 7'd127, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_READ, 32'hFFFF_FFFF, 7'd4, 8'd0, 1'b0, '0});
    plan.push_back('{ROW_REQ, REQ_INSERT, 32'h1234_5678, 7'h7F, 8'd0, 1'b0, '0});

    sz_list = '{3, 16, 2, 40, 0, 90, 128, 255, 0, 127};
    sz_list[8] = $urandom_range(2, 128);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        set_table_size(plan[r].size);
      end else begin
        send_request(plan[r].req, plan[r].key, plan[r].idx, plan[r].typed, plan[r].want);
      end
    end

    foreach (sz_list[p]) begin
      set_table_size(SIZE_W'(sz_list[p]));
      sz = sz_list[p];
      m = (sz < 2) ? 2 : ((sz > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : sz);
      steady = (p == 5);
      if (p == 1) squeeze_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 1) == 0) begin
          send_request(REQ_INSERT, pick_key(m), SLOT_W'($urandom()), 1'b0, '0);
        end else begin
          send_request(REQ_READ, $urandom(),
                       SLOT_W'($urandom_range(0, 1) ? $urandom_range(0, m - 1)
                                                    : $urandom_range(0, 127)),
                       1'b0, '0);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d requests over %0d size settings (0, 1, 2, 128, 255 included)",
             n_sent, n_sizes);
    $display("results: %0d inserted, %0d table full, %0d reads; one %0d-cycle output stall",
             n_inserted, n_full, n_read, SQUEEZE_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
